// ===== hw/rtl/rcs_pkg.sv =====
// Shared types, codes and constants of the robot command sequencer.
`timescale 1ns / 1ps
package rcs_pkg;

	localparam int MAX_CMDS = 16;
	localparam int TAB_AW   = $clog2(MAX_CMDS);

	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_BEGIN  = 3'd1;
	localparam logic [2:0] OP_TICK   = 3'd2;
	localparam logic [2:0] OP_CANCEL = 3'd3;
	localparam logic [2:0] OP_RESET  = 3'd4;

	localparam logic [3:0] K_DRIVE      = 4'd0;
	localparam logic [3:0] K_STRAFE     = 4'd1;
	localparam logic [3:0] K_TURN       = 4'd2;
	localparam logic [3:0] K_VISION     = 4'd3;
	localparam logic [3:0] K_INTAKE_ON  = 4'd4;
	localparam logic [3:0] K_INTAKE_OFF = 4'd5;
	localparam logic [3:0] K_LIFT_ON    = 4'd6;
	localparam logic [3:0] K_LIFT_OFF   = 4'd7;
	localparam logic [3:0] K_DROP       = 4'd8;
	localparam logic [3:0] K_WAIT       = 4'd9;
	localparam logic [3:0] K_STOP       = 4'd10;

	localparam logic [2:0] RS_IDLE = 3'd0;
	localparam logic [2:0] RS_RUN  = 3'd1;
	localparam logic [2:0] RS_FIN  = 3'd2;
	localparam logic [2:0] RS_ERR  = 3'd3;
	localparam logic [2:0] RS_CANC = 3'd4;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_TIMEOUT = 3'd1;
	localparam logic [2:0] E_ABORT   = 3'd2;
	localparam logic [2:0] E_YAW_INV = 3'd3;
	localparam logic [2:0] E_STALE   = 3'd4;
	localparam logic [2:0] E_GUARD   = 3'd5;
	localparam logic [2:0] E_KIND    = 3'd6;

	localparam logic [1:0] D_CONT = 2'd0;
	localparam logic [1:0] D_FIN  = 2'd1;
	localparam logic [1:0] D_SKIP = 2'd2;

	localparam logic [2:0] REG_HH_GAIN   = 3'd0;
	localparam logic [2:0] REG_MAX_CORR  = 3'd1;
	localparam logic [2:0] REG_TURN_GAIN = 3'd2;
	localparam logic [2:0] REG_TURN_LIM  = 3'd3;
	localparam logic [2:0] REG_TURN_TOL  = 3'd4;
	localparam logic [2:0] REG_CMD_TO    = 3'd5;
	localparam logic [2:0] REG_STALE_TO  = 3'd6;
	localparam logic [2:0] REG_MODE      = 3'd7;

	typedef struct packed {
		logic [15:0] hh_gain;
		logic [14:0] max_corr;
		logic [15:0] turn_gain;
		logic [31:0] turn_lim;
		logic [14:0] turn_tol;
		logic [31:0] cmd_to;
		logic [31:0] stale_to;
		logic [1:0]  mode;
	} cfg_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DISP   = 8'b0000_0010,
		ST_STATUS = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_ERR    = 8'b0001_0000,
		ST_MUL    = 8'b0010_0000,
		ST_COMMIT = 8'b0100_0000,
		ST_GUARD  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic read;
		logic calc;
		logic mul;
		logic commit;
		logic status_emit;
		logic guard_emit;
	} ctl_t;

	typedef struct packed {
		logic tick_run;
		logic out_free;
		logic last;
		logic guard_trip;
	} sts_t;

endpackage

// ===== hw/rtl/rcs_cfg.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module rcs_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output rcs_pkg::cfg_t      cfg
);

	rcs_pkg::cfg_t cfg_q;
	logic          wr;

	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hh_gain   <= 16'd1600;
			cfg_q.max_corr  <= 15'd9830;
			cfg_q.turn_gain <= 16'd2400;
			cfg_q.turn_lim  <= 32'd1717976064;
			cfg_q.turn_tol  <= 15'd200;
			cfg_q.cmd_to    <= 32'd0;
			cfg_q.stale_to  <= 32'd0;
			cfg_q.mode      <= 2'd1;
		end else if (wr) begin
			case (paddr[4:2])
				rcs_pkg::REG_HH_GAIN:   cfg_q.hh_gain   <= pwdata[15:0];
				rcs_pkg::REG_MAX_CORR:  cfg_q.max_corr  <= pwdata[14:0];
				rcs_pkg::REG_TURN_GAIN: cfg_q.turn_gain <= pwdata[15:0];
				rcs_pkg::REG_TURN_LIM:  cfg_q.turn_lim  <= pwdata;
				rcs_pkg::REG_TURN_TOL:  cfg_q.turn_tol  <= pwdata[14:0];
				rcs_pkg::REG_CMD_TO:    cfg_q.cmd_to    <= pwdata;
				rcs_pkg::REG_STALE_TO:  cfg_q.stale_to  <= pwdata;
				rcs_pkg::REG_MODE:      cfg_q.mode      <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			rcs_pkg::REG_HH_GAIN:   prdata = {16'd0, cfg_q.hh_gain};
			rcs_pkg::REG_MAX_CORR:  prdata = {17'd0, cfg_q.max_corr};
			rcs_pkg::REG_TURN_GAIN: prdata = {16'd0, cfg_q.turn_gain};
			rcs_pkg::REG_TURN_LIM:  prdata = cfg_q.turn_lim;
			rcs_pkg::REG_TURN_TOL:  prdata = {17'd0, cfg_q.turn_tol};
			rcs_pkg::REG_CMD_TO:    prdata = cfg_q.cmd_to;
			rcs_pkg::REG_STALE_TO:  prdata = cfg_q.stale_to;
			rcs_pkg::REG_MODE:      prdata = {30'd0, cfg_q.mode};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/rcs_ctrl.sv =====
// Controller state machine that sequences the datapath through one item.
`timescale 1ns / 1ps
module rcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rcs_pkg::sts_t sts,
	output rcs_pkg::ctl_t ctl
);

	rcs_pkg::state_t state_q, state_d;

	assign in_stall = (state_q != rcs_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			rcs_pkg::ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = rcs_pkg::ST_DISP;
				end
			end
			rcs_pkg::ST_DISP: begin
				ctl.apply = 1'b1;
				state_d   = sts.tick_run ? rcs_pkg::ST_READ : rcs_pkg::ST_STATUS;
			end
			rcs_pkg::ST_STATUS: begin
				if (sts.out_free) begin
					ctl.status_emit = 1'b1;
					state_d         = rcs_pkg::ST_IDLE;
				end
			end
			rcs_pkg::ST_READ: begin
				ctl.read = 1'b1;
				state_d  = rcs_pkg::ST_ERR;
			end
			rcs_pkg::ST_ERR: begin
				ctl.calc = 1'b1;
				state_d  = rcs_pkg::ST_MUL;
			end
			rcs_pkg::ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = rcs_pkg::ST_COMMIT;
			end
			rcs_pkg::ST_COMMIT: begin
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					if (sts.last)
						state_d = rcs_pkg::ST_IDLE;
					else if (sts.guard_trip)
						state_d = rcs_pkg::ST_GUARD;
					else
						state_d = rcs_pkg::ST_READ;
				end
			end
			rcs_pkg::ST_GUARD: begin
				if (sts.out_free) begin
					ctl.guard_emit = 1'b1;
					state_d        = rcs_pkg::ST_IDLE;
				end
			end
			default: state_d = rcs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/rcs_dp.sv =====
// Datapath: command tables, runner state, heading arithmetic and result register.
`timescale 1ns / 1ps
module rcs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  rcs_pkg::ctl_t      ctl,
	output rcs_pkg::sts_t      sts,
	input  rcs_pkg::cfg_t      cfg,
	input  logic [2:0]         opcode,
	input  logic [4:0]         entry_index,
	input  logic [3:0]         cmd_kind,
	input  logic signed [15:0] arg_a,
	input  logic signed [15:0] arg_b,
	input  logic [31:0]        duration_ms,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] yaw,
	input  logic               yaw_valid,
	input  logic [31:0]        yaw_stamp_ms,
	input  logic               vision_done,
	input  logic               abort_request,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         run_state,
	output logic [4:0]         active_index,
	output logic [2:0]         error_code,
	output logic [1:0]         command_done,
	output logic signed [15:0] forward_power,
	output logic signed [15:0] strafe_power,
	output logic signed [15:0] turn_power,
	output logic               intake_on,
	output logic               lift_on,
	output logic               drop_pulse,
	output logic               vision_active,
	output logic               last
);

	// captured item
	logic [2:0]         op_q;
	logic [4:0]         ei_q;
	logic [3:0]         kind_in_q;
	logic signed [15:0] a_in_q, b_in_q, yaw_q;
	logic [31:0]        dur_in_q, now_q, stamp_q;
	logic               yaw_ok_q, vdone_q, abort_q;

	// tables
	logic [35:0] cmd_mem [rcs_pkg::MAX_CMDS];
	logic [31:0] dur_mem [rcs_pkg::MAX_CMDS];
	logic [35:0] rd_cmd_q;
	logic [31:0] rd_dur_q;

	// runner state
	logic [2:0]  run_q;
	logic [4:0]  idx_q, count_q, guard_q;
	logic        started_q, vision_q, intake_q, lift_q;
	logic [31:0] start_q;

	// per-step intermediates
	logic signed [15:0] err_q;
	logic [14:0]        abs_err_q;
	logic [31:0]        elapsed_q;
	logic               stale_q, tmo_q, dur_done_q;
	logic [30:0]        prod_q;

	// result register
	logic               ov_q;
	logic [2:0]         o_run_q, o_err_q;
	logic [4:0]         o_idx_q;
	logic [1:0]         o_done_q;
	logic signed [15:0] o_fw_q, o_st_q, o_tr_q;
	logic               o_in_q, o_lf_q, o_drop_q, o_vis_q, o_last_q;

	logic [3:0]         kind;
	logic signed [15:0] ta, tb;

	assign kind = rd_cmd_q[3:0];
	assign ta   = rd_cmd_q[19:4];
	assign tb   = rd_cmd_q[35:20];

	// ---------------- capture and table ----------------
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q      <= opcode;
			ei_q      <= entry_index;
			kind_in_q <= cmd_kind;
			a_in_q    <= arg_a;
			b_in_q    <= arg_b;
			dur_in_q  <= duration_ms;
			now_q     <= now_ms;
			yaw_q     <= yaw;
			yaw_ok_q  <= yaw_valid;
			stamp_q   <= yaw_stamp_ms;
			vdone_q   <= vision_done;
			abort_q   <= abort_request;
		end
		if (ctl.apply && op_q == rcs_pkg::OP_LOAD && ei_q < 5'(rcs_pkg::MAX_CMDS)) begin
			cmd_mem[ei_q[rcs_pkg::TAB_AW-1:0]] <= {b_in_q, a_in_q, kind_in_q};
			dur_mem[ei_q[rcs_pkg::TAB_AW-1:0]] <= dur_in_q;
		end
		if (ctl.read) begin
			rd_cmd_q <= cmd_mem[idx_q[rcs_pkg::TAB_AW-1:0]];
			rd_dur_q <= dur_mem[idx_q[rcs_pkg::TAB_AW-1:0]];
		end
	end

	// ---------------- error, age and elapsed ----------------
	logic signed [17:0] d0, d1, d2;
	logic [31:0]        elapsed_c, age_c;

	always_comb begin
		d0 = 18'((kind == rcs_pkg::K_TURN) ? ta : tb) - 18'(yaw_q);
		if (d0 >= 18'sd18000)
			d1 = d0 - 18'sd36000;
		else if (d0 < -18'sd18000)
			d1 = d0 + 18'sd36000;
		else
			d1 = d0;
		if (d1 >= 18'sd18000)
			d2 = d1 - 18'sd36000;
		else if (d1 < -18'sd18000)
			d2 = d1 + 18'sd36000;
		else
			d2 = d1;
		elapsed_c = started_q ? (now_q - start_q) : 32'd0;
		age_c     = now_q - stamp_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			err_q      <= d2[15:0];
			abs_err_q  <= d2[17] ? 15'(-d2) : d2[14:0];
			elapsed_q  <= elapsed_c;
			stale_q    <= (cfg.stale_to != 32'd0) && (stamp_q != 32'd0) &&
				(age_c > cfg.stale_to);
			tmo_q      <= (cfg.cmd_to != 32'd0) && (elapsed_c >= cfg.cmd_to);
			dur_done_q <= elapsed_c >= rd_dur_q;
		end
		if (ctl.mul)
			prod_q <= 31'(abs_err_q) * 31'((kind == rcs_pkg::K_TURN) ? cfg.turn_gain : cfg.hh_gain);
	end

	// ---------------- step decision ----------------
	logic [22:0]        mag;
	logic [14:0]        mx, mn, hc, tc;
	logic               neg;
	logic [2:0]         nx_run, e_err;
	logic [4:0]         nx_idx;
	logic               nx_started, nx_vision, nx_intake, nx_lift;
	logic [31:0]        nx_start;
	logic [1:0]         e_done;
	logic signed [15:0] e_fw, e_st, e_tr;
	logic               e_drop, e_last, fail, fin, skip;
	logic [2:0]         fail_code;
	logic [4:0]         idx_inc;
	logic [5:0]         guard_inc;

	always_comb begin
		mag = prod_q[30:8];
		neg = err_q[15];
		mx  = (cfg.turn_lim[31:16] > 16'd32767) ? 15'd32767 : cfg.turn_lim[30:16];
		mn  = (cfg.turn_lim[15:0] > {1'b0, mx}) ? mx : cfg.turn_lim[14:0];
		hc  = (mag > 23'(cfg.max_corr)) ? cfg.max_corr : mag[14:0];
		tc  = (mag > 23'(mx)) ? mx : mag[14:0];
		if (tc < mn)
			tc = mn;

		nx_run     = run_q;
		nx_idx     = idx_q;
		nx_started = started_q;
		nx_vision  = vision_q;
		nx_intake  = intake_q;
		nx_lift    = lift_q;
		nx_start   = start_q;
		e_err      = rcs_pkg::E_NONE;
		e_done     = rcs_pkg::D_CONT;
		e_fw       = '0;
		e_st       = '0;
		e_tr       = '0;
		e_drop     = 1'b0;
		e_last     = 1'b1;
		fail       = 1'b0;
		fin        = 1'b0;
		skip       = 1'b0;
		fail_code  = rcs_pkg::E_NONE;
		idx_inc    = idx_q + 5'd1;
		guard_inc  = {1'b0, guard_q} + 6'd1;

		if (abort_q) begin
			fail      = 1'b1;
			fail_code = rcs_pkg::E_ABORT;
		end else if (idx_q >= count_q) begin
			nx_lift    = 1'b0;
			nx_run     = rcs_pkg::RS_FIN;
			nx_started = 1'b0;
			nx_vision  = 1'b0;
		end else if (kind <= rcs_pkg::K_TURN && !yaw_ok_q) begin
			fail      = 1'b1;
			fail_code = rcs_pkg::E_YAW_INV;
		end else if (kind <= rcs_pkg::K_TURN && stale_q) begin
			fail      = 1'b1;
			fail_code = rcs_pkg::E_STALE;
		end else begin
			nx_started = 1'b1;
			if (!started_q) begin
				nx_start  = now_q;
				nx_vision = 1'b0;
			end
			case (kind)
				rcs_pkg::K_DRIVE, rcs_pkg::K_STRAFE: begin
					if (dur_done_q) begin
						fin = 1'b1;
					end else begin
						e_tr = neg ? -$signed({1'b0, hc}) : $signed({1'b0, hc});
						if (kind == rcs_pkg::K_DRIVE)
							e_fw = (ta == -16'sd32768) ? -16'sd32767 : ta;
						else
							e_st = (ta == -16'sd32768) ? -16'sd32767 : ta;
					end
				end
				rcs_pkg::K_TURN: begin
					if (abs_err_q <= cfg.turn_tol)
						fin = 1'b1;
					else if (tmo_q) begin
						if (cfg.mode[0]) begin
							fail      = 1'b1;
							fail_code = rcs_pkg::E_TIMEOUT;
						end else
							skip = 1'b1;
					end else
						e_tr = neg ? -$signed({1'b0, tc}) : $signed({1'b0, tc});
				end
				rcs_pkg::K_VISION: begin
					nx_vision = 1'b1;
					if (vdone_q)
						fin = 1'b1;
					else if (tmo_q) begin
						if (cfg.mode[0]) begin
							fail      = 1'b1;
							fail_code = rcs_pkg::E_TIMEOUT;
						end else
							skip = 1'b1;
					end
				end
				rcs_pkg::K_INTAKE_ON: begin
					nx_intake = 1'b1;
					fin       = 1'b1;
				end
				rcs_pkg::K_INTAKE_OFF: begin
					nx_intake = 1'b0;
					fin       = 1'b1;
				end
				rcs_pkg::K_LIFT_ON: begin
					nx_lift = 1'b1;
					fin     = 1'b1;
				end
				rcs_pkg::K_LIFT_OFF: begin
					nx_lift = 1'b0;
					fin     = 1'b1;
				end
				rcs_pkg::K_DROP, rcs_pkg::K_STOP: fin = 1'b1;
				rcs_pkg::K_WAIT: fin = dur_done_q;
				default: begin
					fail      = 1'b1;
					fail_code = rcs_pkg::E_KIND;
				end
			endcase
			if (fin || skip) begin
				nx_started = 1'b0;
				nx_vision  = 1'b0;
				e_done     = skip ? rcs_pkg::D_SKIP : rcs_pkg::D_FIN;
				e_err      = skip ? rcs_pkg::E_TIMEOUT : rcs_pkg::E_NONE;
				e_drop     = fin && kind == rcs_pkg::K_DROP;
				if (skip)
					nx_lift = 1'b0;
				if (fin && kind == rcs_pkg::K_STOP) begin
					nx_lift = 1'b0;
					nx_run  = rcs_pkg::RS_FIN;
				end else begin
					nx_idx = idx_inc;
					if (idx_inc >= count_q) begin
						nx_lift = 1'b0;
						nx_run  = rcs_pkg::RS_FIN;
					end
				end
				e_last = (nx_run != rcs_pkg::RS_RUN);
			end
		end
		if (fail) begin
			nx_vision  = 1'b0;
			nx_lift    = 1'b0;
			nx_run     = rcs_pkg::RS_ERR;
			nx_started = 1'b0;
			e_err      = fail_code;
			e_fw       = '0;
			e_st       = '0;
			e_tr       = '0;
			e_last     = 1'b1;
		end
	end

	assign sts.tick_run   = (op_q == rcs_pkg::OP_TICK) && (run_q == rcs_pkg::RS_RUN);
	assign sts.out_free   = !ov_q || !out_stall;
	assign sts.last       = e_last;
	assign sts.guard_trip = guard_inc >= {1'b0, count_q};

	// ---------------- runner state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= rcs_pkg::RS_IDLE;
			idx_q     <= '0;
			count_q   <= '0;
			guard_q   <= '0;
			started_q <= 1'b0;
			vision_q  <= 1'b0;
			intake_q  <= 1'b0;
			lift_q    <= 1'b0;
			start_q   <= '0;
		end else begin
			if (ctl.apply) begin
				guard_q <= '0;
				case (op_q)
					rcs_pkg::OP_BEGIN: begin
						count_q   <= (ei_q > 5'(rcs_pkg::MAX_CMDS)) ?
							5'(rcs_pkg::MAX_CMDS) : ei_q;
						idx_q     <= '0;
						started_q <= 1'b0;
						vision_q  <= 1'b0;
						start_q   <= '0;
						run_q     <= (ei_q == 5'd0) ? rcs_pkg::RS_FIN : rcs_pkg::RS_RUN;
					end
					rcs_pkg::OP_CANCEL: begin
						if (run_q == rcs_pkg::RS_RUN) begin
							vision_q <= 1'b0;
							lift_q   <= 1'b0;
							run_q    <= rcs_pkg::RS_CANC;
						end
					end
					rcs_pkg::OP_RESET: begin
						count_q   <= '0;
						idx_q     <= '0;
						run_q     <= rcs_pkg::RS_IDLE;
						started_q <= 1'b0;
						vision_q  <= 1'b0;
						start_q   <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.commit) begin
				run_q     <= nx_run;
				idx_q     <= nx_idx;
				started_q <= nx_started;
				vision_q  <= nx_vision;
				intake_q  <= nx_intake;
				lift_q    <= nx_lift;
				start_q   <= nx_start;
				guard_q   <= guard_inc[4:0];
			end
			if (ctl.guard_emit) begin
				vision_q  <= 1'b0;
				lift_q    <= 1'b0;
				run_q     <= rcs_pkg::RS_ERR;
				started_q <= 1'b0;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctl.status_emit || ctl.commit || ctl.guard_emit) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.status_emit) begin
			o_run_q  <= run_q;
			o_idx_q  <= idx_q;
			o_err_q  <= rcs_pkg::E_NONE;
			o_done_q <= rcs_pkg::D_CONT;
			o_fw_q   <= '0;
			o_st_q   <= '0;
			o_tr_q   <= '0;
			o_in_q   <= intake_q;
			o_lf_q   <= lift_q;
			o_drop_q <= 1'b0;
			o_vis_q  <= vision_q;
			o_last_q <= 1'b1;
		end else if (ctl.commit) begin
			o_run_q  <= nx_run;
			o_idx_q  <= idx_q;
			o_err_q  <= e_err;
			o_done_q <= e_done;
			o_fw_q   <= e_fw;
			o_st_q   <= e_st;
			o_tr_q   <= e_tr;
			o_in_q   <= nx_intake;
			o_lf_q   <= nx_lift;
			o_drop_q <= e_drop;
			o_vis_q  <= nx_vision;
			o_last_q <= e_last;
		end else if (ctl.guard_emit) begin
			o_run_q  <= rcs_pkg::RS_ERR;
			o_idx_q  <= idx_q;
			o_err_q  <= rcs_pkg::E_GUARD;
			o_done_q <= rcs_pkg::D_CONT;
			o_fw_q   <= '0;
			o_st_q   <= '0;
			o_tr_q   <= '0;
			o_in_q   <= intake_q;
			o_lf_q   <= 1'b0;
			o_drop_q <= 1'b0;
			o_vis_q  <= 1'b0;
			o_last_q <= 1'b1;
		end
	end

	assign out_valid     = ov_q;
	assign run_state     = o_run_q;
	assign active_index  = o_idx_q;
	assign error_code    = o_err_q;
	assign command_done  = o_done_q;
	assign forward_power = o_fw_q;
	assign strafe_power  = o_st_q;
	assign turn_power    = o_tr_q;
	assign intake_on     = o_in_q;
	assign lift_on       = o_lf_q;
	assign drop_pulse    = o_drop_q;
	assign vision_active = o_vis_q;
	assign last          = o_last_q;

endmodule

// ===== hw/rtl/robot_command_sequencer.sv =====
// Top level of the robot command sequencer.
//
//  channel  handshake            payload
//  input    in_valid / in_stall  opcode .. abort_request, one item per command
//  output   out_valid/out_stall  run_state .. last, one or more items per input
//  config   psel/penable/pready  paddr[4:2] selects register, pwdata/prdata
//
// A non-tick item, or a tick while the runner is not running, passes through
// capture, apply and status emit. A tick steps through table read, yaw error and
// age, gain multiply and commit for each table command that it chains.
// Reset clears the runner state and loads register defaults; tables hold no
// value until loaded. A stalled output holds the controller in its emit state.
`timescale 1ns / 1ps
module robot_command_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  logic [4:0]         entry_index,
	input  logic [3:0]         cmd_kind,
	input  logic signed [15:0] arg_a,
	input  logic signed [15:0] arg_b,
	input  logic [31:0]        duration_ms,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] yaw,
	input  logic               yaw_valid,
	input  logic [31:0]        yaw_stamp_ms,
	input  logic               vision_done,
	input  logic               abort_request,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         run_state,
	output logic [4:0]         active_index,
	output logic [2:0]         error_code,
	output logic [1:0]         command_done,
	output logic signed [15:0] forward_power,
	output logic signed [15:0] strafe_power,
	output logic signed [15:0] turn_power,
	output logic               intake_on,
	output logic               lift_on,
	output logic               drop_pulse,
	output logic               vision_active,
	output logic               last
);

	rcs_pkg::cfg_t cfg;
	rcs_pkg::ctl_t ctl;
	rcs_pkg::sts_t sts;

	assign pready = 1'b1;

	rcs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	rcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	rcs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cfg           (cfg),
		.opcode        (opcode),
		.entry_index   (entry_index),
		.cmd_kind      (cmd_kind),
		.arg_a         (arg_a),
		.arg_b         (arg_b),
		.duration_ms   (duration_ms),
		.now_ms        (now_ms),
		.yaw           (yaw),
		.yaw_valid     (yaw_valid),
		.yaw_stamp_ms  (yaw_stamp_ms),
		.vision_done   (vision_done),
		.abort_request (abort_request),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.run_state     (run_state),
		.active_index  (active_index),
		.error_code    (error_code),
		.command_done  (command_done),
		.forward_power (forward_power),
		.strafe_power  (strafe_power),
		.turn_power    (turn_power),
		.intake_on     (intake_on),
		.lift_on       (lift_on),
		.drop_pulse    (drop_pulse),
		.vision_active (vision_active),
		.last          (last)
	);

endmodule
